// ----- src/crc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock replacement cache tags: shared package
// Field widths, access kinds, controller states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package crc_pkg;

	// Widths of the fields on the ports.
	localparam int KIND_W   = 2;
	localparam int SECTOR_W = 32;
	localparam int SLOT_W   = 6;

	// Default number of cache slots.
	localparam int CRC_SLOTS = 64;

	// Access kinds; the fourth code means nothing and is dropped.
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SWEEP,
		ST_FINISH,
		ST_FL_SCAN,
		ST_FL_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;       // capture the input word and restart the scan
		logic issue;       // issue the next tag read of the lookup scan
		logic take_hit;    // the slot in the compare stage is the result
		logic take_free;   // the first empty slot seen is the result
		logic sweep_clear; // clear the reference mark under the hand, advance
		logic sweep_pick;  // the slot under the hand is the victim
		logic finish;      // load the access result and update the marks
		logic fl_read;     // read the tag of the flush slot
		logic fl_emit;     // load a flush writeback result
		logic idx_step;    // move the flush index on
	} crc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;       // compare stage matches an occupied slot
		logic cmp_last;  // compare stage holds the last slot
		logic free_any;  // an empty slot has been seen in this scan
		logic iss_end;   // every slot has been issued
		logic hand_ref;  // reference mark under the hand is set
		logic out_free;  // output register can take a word this cycle
		logic fl_qual;   // flush slot is occupied and dirty
		logic idx_last;  // flush index is at the last slot
	} crc_status_t;

endpackage

// ----- src/crc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module crc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/crc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock replacement cache tags: controller
// Sequences the lookup scan, the clock sweep, the result and the flush walk.
// ----------------------------------------------------------------------------
module crc_ctrl import crc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [KIND_W-1:0] kind,
	input  crc_status_t       st,
	output crc_cmd_t          cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (kind) inside
						KIND_READ, KIND_WRITE: state_d = ST_LOOKUP;
						KIND_FLUSH:            state_d = ST_FL_SCAN;
						default:               state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOOKUP: begin
				if (st.hit) begin
					state_d = ST_FINISH;
				end else if (st.cmp_last) begin
					state_d = st.free_any ? ST_FINISH : ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (!st.hand_ref) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_FL_SCAN: begin
				if (st.fl_qual) begin
					state_d = ST_FL_EMIT;
				end else if (st.idx_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_FL_EMIT: begin
				if (st.out_free) begin
					state_d = st.idx_last ? ST_IDLE : ST_FL_SCAN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_LOOKUP: begin
				cmd.issue = !st.iss_end;
				if (st.hit) begin
					cmd.take_hit = 1'b1;
				end else if (st.cmp_last && st.free_any) begin
					cmd.take_free = 1'b1;
				end
			end
			ST_SWEEP: begin
				cmd.sweep_clear = st.hand_ref;
				cmd.sweep_pick  = !st.hand_ref;
			end
			ST_FINISH: begin
				cmd.finish = st.out_free;
			end
			ST_FL_SCAN: begin
				cmd.fl_read  = st.fl_qual;
				cmd.idx_step = !st.fl_qual && !st.idx_last;
			end
			ST_FL_EMIT: begin
				cmd.fl_emit  = st.out_free;
				cmd.idx_step = st.out_free && !st.idx_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- src/crc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock replacement cache tags: datapath
// Tag RAM, slot marks, clock hand, scan index and the output register.
// ----------------------------------------------------------------------------
module crc_dp import crc_pkg::*; #(
	parameter int SLOTS = CRC_SLOTS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [KIND_W-1:0]   kind,
	input  logic [SECTOR_W-1:0] access_sector,
	input  crc_cmd_t            cmd,
	output crc_status_t         st,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SLOT_W-1:0]   slot,
	output logic                hit,
	output logic                fill_needed,
	output logic                writeback_needed,
	output logic [SECTOR_W-1:0] writeback_sector,
	output logic                last
);

	localparam int IW = $clog2(SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	// Captured input word.
	logic [KIND_W-1:0]   kind_q;
	logic [SECTOR_W-1:0] sector_q;

	// Scan and victim bookkeeping.
	logic [IW-1:0] idx_q;
	logic          iss_end_q;
	logic          cmp_vld_s1;
	logic [IW-1:0] cmp_idx_s1;
	logic          free_vld_q;
	logic [IW-1:0] free_idx_q;
	logic [IW-1:0] victim_q;
	logic          from_sweep_q;
	logic          res_hit_q;
	logic [IW-1:0] hand_q;

	// Slot marks.
	logic [SLOTS-1:0] empty_q;
	logic [SLOTS-1:0] dirty_q;
	logic [SLOTS-1:0] ref_q;

	// Output register.
	logic                out_valid_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                hit_q;
	logic                fill_q;
	logic                wb_q;
	logic [SECTOR_W-1:0] wsec_q;
	logic                last_q;

	// Tag RAM connections.
	logic                ram_we;
	logic                ram_re;
	logic [IW-1:0]       ram_raddr;
	logic [SECTOR_W-1:0] ram_rdata;

	logic [SLOTS-1:0] occ_dirty;
	logic [SLOTS-1:0] above;
	logic             fl_more;
	logic             fin_wb;
	logic [IW-1:0]    victim_next;
	logic             is_write;

	// Tag store.
	assign ram_we    = cmd.finish && !res_hit_q;
	assign ram_re    = cmd.issue || cmd.sweep_pick || cmd.fl_read;
	assign ram_raddr = cmd.sweep_pick ? hand_q : idx_q;

	crc_ram #(
		.WIDTH (SECTOR_W),
		.DEPTH (SLOTS)
	) u_tags (
		.clk   (clk),
		.we    (ram_we),
		.waddr (victim_q),
		.wdata (sector_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Dirty occupied slots beyond the flush index decide the last flag.
	always_comb begin
		occ_dirty = ~empty_q & dirty_q;
		for (int j = 0; j < SLOTS; j++) begin
			above[j] = IW'(j) > idx_q;
		end
		fl_more = |(occ_dirty & above);
	end

	assign fin_wb      = from_sweep_q && dirty_q[victim_q];
	assign victim_next = (victim_q == LAST_IDX) ? '0 : victim_q + 1'b1;
	assign is_write    = kind_q == KIND_WRITE;

	// Status towards the controller.
	always_comb begin
		st          = '0;
		st.hit      = cmp_vld_s1 && !empty_q[cmp_idx_s1] && (ram_rdata == sector_q);
		st.cmp_last = cmp_vld_s1 && (cmp_idx_s1 == LAST_IDX);
		st.free_any = free_vld_q || (cmp_vld_s1 && empty_q[cmp_idx_s1]);
		st.iss_end  = iss_end_q;
		st.hand_ref = ref_q[hand_q];
		st.out_free = !out_valid_q || out_ready;
		st.fl_qual  = occ_dirty[idx_q];
		st.idx_last = idx_q == LAST_IDX;
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q   <= kind;
			sector_q <= access_sector;
		end
	end

	// Scan index and compare stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			iss_end_q  <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			free_vld_q <= 1'b0;
			free_idx_q <= '0;
		end else begin
			cmp_vld_s1 <= cmd.issue;
			if (cmd.issue) begin
				cmp_idx_s1 <= idx_q;
			end
			if (cmd.start) begin
				idx_q      <= '0;
				iss_end_q  <= 1'b0;
				free_vld_q <= 1'b0;
			end else begin
				if (cmd.issue || cmd.idx_step) begin
					idx_q <= idx_q + 1'b1;
				end
				if (cmd.issue && idx_q == LAST_IDX) begin
					iss_end_q <= 1'b1;
				end
				if (cmp_vld_s1 && empty_q[cmp_idx_s1] && !free_vld_q) begin
					free_vld_q <= 1'b1;
					free_idx_q <= cmp_idx_s1;
				end
			end
		end
	end

	// Victim choice and clock hand.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			victim_q     <= '0;
			from_sweep_q <= 1'b0;
			res_hit_q    <= 1'b0;
			hand_q       <= '0;
		end else begin
			if (cmd.take_hit) begin
				victim_q     <= cmp_idx_s1;
				res_hit_q    <= 1'b1;
				from_sweep_q <= 1'b0;
			end else if (cmd.take_free) begin
				victim_q     <= free_vld_q ? free_idx_q : cmp_idx_s1;
				res_hit_q    <= 1'b0;
				from_sweep_q <= 1'b0;
			end else if (cmd.sweep_pick) begin
				victim_q     <= hand_q;
				res_hit_q    <= 1'b0;
				from_sweep_q <= 1'b1;
			end
			if (cmd.sweep_clear) begin
				hand_q <= (hand_q == LAST_IDX) ? '0 : hand_q + 1'b1;
			end else if (cmd.finish && from_sweep_q) begin
				hand_q <= victim_next;
			end
		end
	end

	// Slot marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= '1;
			dirty_q <= '0;
			ref_q   <= '0;
		end else begin
			if (cmd.sweep_clear) begin
				ref_q[hand_q] <= 1'b0;
			end
			if (cmd.finish) begin
				ref_q[victim_q] <= 1'b1;
				if (res_hit_q) begin
					dirty_q[victim_q] <= dirty_q[victim_q] || is_write;
				end else begin
					empty_q[victim_q] <= 1'b0;
					dirty_q[victim_q] <= is_write;
				end
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish || cmd.fl_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register word.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			slot_q <= SLOT_W'(victim_q);
			hit_q  <= res_hit_q;
			fill_q <= !res_hit_q;
			wb_q   <= fin_wb;
			wsec_q <= fin_wb ? ram_rdata : '0;
			last_q <= 1'b1;
		end else if (cmd.fl_emit) begin
			slot_q <= SLOT_W'(idx_q);
			hit_q  <= 1'b0;
			fill_q <= 1'b0;
			wb_q   <= 1'b1;
			wsec_q <= ram_rdata;
			last_q <= !fl_more;
		end
	end

	assign out_valid        = out_valid_q;
	assign slot             = slot_q;
	assign hit              = hit_q;
	assign fill_needed      = fill_q;
	assign writeback_needed = wb_q;
	assign writeback_sector = wsec_q;
	assign last             = last_q;

`ifndef SYNTHESIS
	a_hand_range: assert property (@(posedge clk) disable iff (!arst_n)
		hand_q <= LAST_IDX)
		else $error("clock hand beyond the last slot");

	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && hit_q |-> !fill_q && !wb_q)
		else $error("hit word carries a fill or a writeback");

	a_wsec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !wb_q |-> wsec_q == '0)
		else $error("writeback sector set without a writeback");

	a_installed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !empty_q[$past(victim_q)])
		else $error("finished slot still marked empty");

	a_one_pick: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take_hit, cmd.take_free, cmd.sweep_pick, cmd.sweep_clear}))
		else $error("more than one victim source in one cycle");
`endif

endmodule

// ----- src/clock_replacement_cache_tags_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock replacement cache tags core
// Tag and clock (second-chance) replacement engine for a fully associative
// sector cache, with a flush walk that reports every dirty slot.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake             Word
// in       input      in_valid / in_ready   kind, access_sector
// out      output     out_valid / out_ready slot, hit, fill_needed,
//                                           writeback_needed, writeback_sector, last
//
// A read or write is accepted, then a lookup scan reads the tags (one tag RAM
// read a cycle) and the result is loaded; a full cache adds a clock sweep
// before the load. A flush steps over each clean slot and reads, then emits,
// each dirty slot.
// Reset clears all marks and the hand at once; the tag RAM needs no clearing.
// A full output register stalls the result load and the flush walk, and a new
// word is taken only once the previous one has loaded its last result.
//
module clock_replacement_cache_tags_core import crc_pkg::*; #(
	parameter int SLOTS = CRC_SLOTS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [KIND_W-1:0]   kind,
	input  logic [SECTOR_W-1:0] access_sector,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SLOT_W-1:0]   slot,
	output logic                hit,
	output logic                fill_needed,
	output logic                writeback_needed,
	output logic [SECTOR_W-1:0] writeback_sector,
	output logic                last
);

	crc_cmd_t    cmd;
	crc_status_t st;

	// Sequencer.
	crc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.st       (st),
		.cmd      (cmd)
	);

	// Tags, marks, hand and output register.
	crc_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.kind             (kind),
		.access_sector    (access_sector),
		.cmd              (cmd),
		.st               (st),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.slot             (slot),
		.hit              (hit),
		.fill_needed      (fill_needed),
		.writeback_needed (writeback_needed),
		.writeback_sector (writeback_sector),
		.last             (last)
	);

endmodule
